[rtl/b64e_pkg.sv]
// base64 encoder package: command word passed from front to back, queue sizing
// and the 6-bit to ASCII alphabet lookup; no dependencies
`default_nettype none

package b64e_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_CHARS   = 4;

    localparam logic [7:0] CHAR_PAD   = 8'h3d;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2f;  // '/'

    // one output character: either padding or a 6-bit alphabet index
    typedef struct packed {
        logic       pad;
        logic [5:0] code;
    } char_t;

    // all characters caused by one input byte
    typedef struct packed {
        char_t [MAX_CHARS-1:0] chars;
        logic  [1:0]           last_idx;
        logic                  eot;
    } cmd_t;

    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26)
        begin
            r = 8'h41 + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            r = 8'h61 + {2'b00, v} - 8'd26;
        end
        else if (v < 6'd62)
        begin
            r = 8'h30 + {2'b00, v} - 8'd52;
        end
        else if (v == 6'd62)
        begin
            r = CHAR_PLUS;
        end
        else
        begin
            r = CHAR_SLASH;
        end
        return r;
    endfunction

    function automatic logic [7:0] to_ascii(input char_t c);
        return c.pad ? CHAR_PAD : sym(c.code);
    endfunction

endpackage

`default_nettype wire

[rtl/b64e_front.sv]
// base64 encoder front: accepts bytes, tracks group phase and leftover bits,
// and turns each byte into a character command; uses b64e_pkg
`default_nettype none

module b64e_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [7:0]     data_byte,
    input  wire logic           last_byte,
    output logic                push,
    output b64e_pkg::cmd_t      cmd,
    input  wire logic           q_full
);
    import b64e_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] left_reg, left_next;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        cmd        = '0;
        phase_next = 2'd0;
        left_next  = 4'd0;
        unique case (phase_reg)
            2'd1:
            begin
                cmd.chars[0].code = {left_reg[1:0], data_byte[7:4]};
                if (last_byte)
                begin
                    cmd.chars[1].code = {data_byte[3:0], 2'b00};
                    cmd.chars[2].pad  = 1'b1;
                    cmd.last_idx      = 2'd2;
                    cmd.eot           = 1'b1;
                end
                else
                begin
                    left_next  = data_byte[3:0];
                    phase_next = 2'd2;
                end
            end
            2'd2:
            begin
                cmd.chars[0].code = {left_reg, data_byte[7:6]};
                cmd.chars[1].code = data_byte[5:0];
                cmd.last_idx      = 2'd1;
                cmd.eot           = last_byte;
            end
            default:
            begin
                // phase 3 never arises from reset and behaves as phase 0
                cmd.chars[0].code = data_byte[7:2];
                if (last_byte)
                begin
                    cmd.chars[1].code = {data_byte[1:0], 4'b0000};
                    cmd.chars[2].pad  = 1'b1;
                    cmd.chars[3].pad  = 1'b1;
                    cmd.last_idx      = 2'd3;
                    cmd.eot           = 1'b1;
                end
                else
                begin
                    left_next  = {2'b00, data_byte[1:0]};
                    phase_next = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            left_reg  <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

[rtl/b64e_queue.sv]
// base64 encoder command queue between front and back, small register fifo;
// uses b64e_pkg
`default_nettype none

module b64e_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire b64e_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output b64e_pkg::cmd_t      head
);
    import b64e_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

    cmd_t            entries_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full      = (count_reg == DepthC);
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/b64e_back.sv]
// base64 encoder back: steps through the characters of each command, maps
// them to ASCII and holds them in the output register; uses b64e_pkg
`default_nettype none

module b64e_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire b64e_pkg::cmd_t q_head,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_char,
    output logic                end_of_text
);
    import b64e_pkg::*;

    logic       busy_reg;
    cmd_t       cmd_reg;
    logic [1:0] idx_reg;
    logic       ovalid_reg;
    logic [7:0] ochar_reg;
    logic       oeot_reg;
    logic       load_out;
    logic       idx_last;

    assign load_out = busy_reg && (!ovalid_reg || out_ready);
    assign idx_last = (idx_reg == cmd_reg.last_idx);
    assign pop      = q_valid && (!busy_reg || (load_out && idx_last));

    assign out_valid   = ovalid_reg;
    assign out_char    = ochar_reg;
    assign end_of_text = oeot_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= q_head;
        end
        if (load_out)
        begin
            ochar_reg <= to_ascii(cmd_reg.chars[idx_reg]);
            oeot_reg  <= cmd_reg.eot && idx_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end

            if (pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 2'd0;
            end
            else if (load_out)
            begin
                // last character of this command gone and nothing queued
                if (idx_last)
                begin
                    busy_reg <= 1'b0;
                end
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/base64_byte_encoder_core.sv]
// Streaming base64 encoder, standard alphabet with '=' padding.
// Input stream: one raw byte per word on s_axis, s_axis_tlast marks the final
// byte of the stream. Output stream: one ASCII character per word on m_axis,
// m_axis_tlast marks the final character (the last one after padding).
// Each byte yields one character (first or second byte of a group), two
// (third byte, even if last), or three to four when it ends the stream
// partway through a group (flush and pads). The byte's command is written
// to the queue, popped into the back end's command register, and its first
// character goes to the output register. Throughput is one character per
// cycle while m_axis_tready is high, set by the back end's single output
// register; bytes are taken back to back while the two-entry queue has room.
// Reset clears group phase, leftover bits, the queue and the output valid.
// When m_axis_tready is low the character is held, the queue fills, and
// s_axis_tready drops once the queue is full.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
`default_nettype none

module base64_byte_encoder_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic       s_axis_tlast,   // last_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_char
    output logic            m_axis_tlast    // end_of_text
);
    import b64e_pkg::*;

    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    cmd_t front_cmd;
    cmd_t q_head;

    b64e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .push      (push),
        .cmd       (front_cmd),
        .q_full    (q_full)
    );

    b64e_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_char    (m_axis_tdata),
        .end_of_text (m_axis_tlast)
    );

endmodule

`default_nettype wire
